// ===== design/sbsd_pkg.sv =====
// Shared types and constants for the serial byte stream deframer.
package sbsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int MAXLEN_W   = 7;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // frame_mode codes
    localparam logic [MODE_W-1:0] MODE_LINE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LENPRE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_CR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_END  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEN   = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'd13;
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'd10;

    localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_PUSH = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input request taken this cycle
        logic rd_en;     // read next buffered byte into the pending register
        logic load_out;  // move pending result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic single;    // accepted byte gives one result, now pending
        logic drain;     // accepted byte releases the buffered line
        logic draining;  // a line release is in progress
        logic pend_last; // pending result is the last of the release
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== design/serial_byte_stream_deframer_top.sv =====
// Top level of the serial byte stream deframer: controller plus datapath.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------------
//  rx      | in        | i_rx_valid / o_rx_stall     | i_rx_byte
//  frame   | out       | o_frame_valid / i_frame_stall | o_frame_byte, o_frame_last,
//          |           |                             | o_result_kind
//  cfg     | in        | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// A request that gives no result is taken in the idle state; one that gives a single result
// is accepted, then pushed to the output register. Releasing a line reads the single-port
// line store one byte at a time into a registered pending slot, then moves each byte to
// the output register, alternating read and push states until the last byte.
// Reset is synchronous, active low; it clears config, counters and the output valid.
// The line store has no reset and no clearing pass: only entries below the fill count
// are ever read. A stall on the frame side holds the controller in its push state.
module serial_byte_stream_deframer_top #(
    parameter int LINE_DEPTH = 64   // line store depth, 2..64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sbsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // received byte requests
    input  logic                            i_rx_valid,
    output logic                            o_rx_stall,
    input  logic [sbsd_pkg::BYTE_W-1:0]     i_rx_byte,
    // result requests
    output logic                            o_frame_valid,
    input  logic                            i_frame_stall,
    output logic [sbsd_pkg::BYTE_W-1:0]     o_frame_byte,
    output logic                            o_frame_last,
    output logic [sbsd_pkg::KIND_W-1:0]     o_result_kind
);

    sbsd_pkg::t_cmd    cmd;
    sbsd_pkg::t_status status;

    // controller: idle / read / push sequencing
    sbsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_status   (status),
        .o_rx_stall (o_rx_stall),
        .o_cmd      (cmd)
    );

    // datapath: config registers, line store, counters, output register
    sbsd_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_frame_stall (i_frame_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_frame_valid (o_frame_valid),
        .o_frame_byte  (o_frame_byte),
        .o_frame_last  (o_frame_last),
        .o_result_kind (o_result_kind)
    );

endmodule

// ===== design/sbsd_ctrl.sv =====
// Controller state machine of the serial byte stream deframer.
module sbsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rx_valid,
    input  sbsd_pkg::t_status i_status,
    output logic             o_rx_stall,
    output sbsd_pkg::t_cmd   o_cmd
);

    sbsd_pkg::t_state r_state;
    sbsd_pkg::t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.accept    = 1'b0;
        o_cmd.rd_en     = 1'b0;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            sbsd_pkg::ST_IDLE: begin
                o_cmd.accept = i_rx_valid;
                if (i_rx_valid) begin
                    if (i_status.drain) begin
                        n_state = sbsd_pkg::ST_READ;
                    end else if (i_status.single) begin
                        n_state = sbsd_pkg::ST_PUSH;
                    end
                end
            end
            sbsd_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = sbsd_pkg::ST_PUSH;
            end
            sbsd_pkg::ST_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = (i_status.draining && !i_status.pend_last) ?
                              sbsd_pkg::ST_READ : sbsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rx_stall = (r_state != sbsd_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a buffered read always lands in the pending register next cycle
    a_read_then_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbsd_pkg::ST_READ) |=> (r_state == sbsd_pkg::ST_PUSH))
        else $error("read not followed by push");

    // a release in progress never returns to idle before its last byte goes out
    a_drain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbsd_pkg::ST_PUSH && i_status.draining && !i_status.pend_last
         && i_status.out_free) |=> (r_state == sbsd_pkg::ST_READ))
        else $error("release cut short");

endmodule

// ===== design/sbsd_dp.sv =====
// Datapath of the serial byte stream deframer: config, line store, counters, output.
module sbsd_dp #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sbsd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sbsd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [sbsd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  logic                                i_frame_stall,
    input  sbsd_pkg::t_cmd                      i_cmd,
    output sbsd_pkg::t_status                   o_status,
    output logic                                o_frame_valid,
    output logic [sbsd_pkg::BYTE_W-1:0]         o_frame_byte,
    output logic                                o_frame_last,
    output logic [sbsd_pkg::KIND_W-1:0]         o_result_kind
);

    localparam int IW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam logic [sbsd_pkg::MAXLEN_W-1:0] DEPTH_LIM = sbsd_pkg::MAXLEN_W'(LINE_DEPTH);

    // configuration
    logic [sbsd_pkg::MODE_W-1:0]   r_mode;
    logic [sbsd_pkg::BYTE_W-1:0]   r_line_end;
    logic                          r_strip_cr;
    logic [sbsd_pkg::BYTE_W-1:0]   r_custom_end;
    logic [sbsd_pkg::MAXLEN_W-1:0] r_max_len;
    logic [sbsd_pkg::BYTE_W-1:0]   r_fixed_len;

    // framing state
    logic [FW-1:0]                 r_fill, n_fill;
    logic                          r_last_cr, n_last_cr;
    logic [sbsd_pkg::BYTE_W-1:0]   r_left, n_left;
    logic                          r_await, n_await;
    logic [FW-1:0]                 r_drain_len, n_drain_len;
    logic [IW-1:0]                 r_rd_idx, n_rd_idx;
    logic                          r_draining, n_draining;

    // pending result and output register
    logic [sbsd_pkg::BYTE_W-1:0]   r_pend_byte;
    logic                          r_pend_last;
    logic [sbsd_pkg::KIND_W-1:0]   r_pend_kind;
    logic                          r_out_valid;
    logic [sbsd_pkg::BYTE_W-1:0]   r_out_byte;
    logic                          r_out_last;
    logic [sbsd_pkg::KIND_W-1:0]   r_out_kind;

    logic [sbsd_pkg::BYTE_W-1:0]   line_mem [LINE_DEPTH];

    // decode of the accepted byte
    logic                          dec_single;
    logic                          dec_drain;
    logic                          dec_append;
    logic [sbsd_pkg::BYTE_W-1:0]   dec_byte;
    logic                          dec_last;
    logic [sbsd_pkg::KIND_W-1:0]   dec_kind;
    logic [sbsd_pkg::BYTE_W-1:0]   delim;
    logic                          strip;
    logic [sbsd_pkg::MAXLEN_W-1:0] limit;
    logic [FW-1:0]                 keep;
    logic [sbsd_pkg::BYTE_W-1:0]   left_start;
    logic [sbsd_pkg::BYTE_W-1:0]   left_dec;
    logic                          out_free;

    assign out_free = !r_out_valid || !i_frame_stall;
    assign limit    = (r_max_len > DEPTH_LIM) ? DEPTH_LIM : r_max_len;
    assign delim    = (r_mode == sbsd_pkg::MODE_LINE) ? r_line_end : r_custom_end;
    assign strip    = (r_mode == sbsd_pkg::MODE_LINE) && r_strip_cr;
    assign keep     = (strip && r_last_cr) ? (r_fill - FW'(1)) : r_fill;
    assign left_start = (r_left == '0) ? r_fixed_len : r_left;
    assign left_dec   = left_start - 8'd1;

    always_comb begin
        n_fill      = r_fill;
        n_last_cr   = r_last_cr;
        n_left      = r_left;
        n_await     = r_await;
        n_drain_len = r_drain_len;
        n_rd_idx    = r_rd_idx;
        n_draining  = r_draining;
        dec_single  = 1'b0;
        dec_drain   = 1'b0;
        dec_append  = 1'b0;
        dec_byte    = i_rx_byte;
        dec_last    = 1'b1;
        dec_kind    = sbsd_pkg::KIND_DATA;
        unique case (r_mode)
            sbsd_pkg::MODE_LINE, sbsd_pkg::MODE_CUSTOM: begin
                if (i_rx_byte == delim) begin
                    if (r_fill != '0) begin
                        n_fill    = '0;
                        n_last_cr = 1'b0;
                        if (keep == '0) begin
                            // lone CR: empty line
                            dec_single = 1'b1;
                            dec_byte   = '0;
                            dec_kind   = sbsd_pkg::KIND_EMPTY;
                        end else begin
                            dec_drain   = 1'b1;
                            n_drain_len = keep;
                            n_rd_idx    = '0;
                            n_draining  = 1'b1;
                        end
                    end
                end else if (sbsd_pkg::MAXLEN_W'(r_fill) >= limit) begin
                    n_fill     = '0;
                    n_last_cr  = 1'b0;
                    dec_single = 1'b1;
                    dec_byte   = '0;
                    dec_kind   = sbsd_pkg::KIND_OVERFLOW;
                end else begin
                    dec_append = 1'b1;
                    n_fill     = r_fill + FW'(1);
                    n_last_cr  = (i_rx_byte == sbsd_pkg::CR_BYTE);
                end
            end
            sbsd_pkg::MODE_FIXED: begin
                if (r_fixed_len != '0) begin
                    n_left     = left_dec;
                    dec_single = 1'b1;
                    dec_last   = (left_dec == '0);
                end
            end
            sbsd_pkg::MODE_LENPRE: begin
                if (r_await || r_left == '0) begin
                    if (i_rx_byte == '0) begin
                        n_await = 1'b1;
                    end else begin
                        n_left  = i_rx_byte;
                        n_await = 1'b0;
                    end
                end else begin
                    n_left     = r_left - 8'd1;
                    dec_single = 1'b1;
                    dec_last   = (r_left == 8'd1);
                    if (r_left == 8'd1) begin
                        n_await = 1'b1;
                    end
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
        if (!i_cmd.accept) begin
            n_fill      = r_fill;
            n_last_cr   = r_last_cr;
            n_left      = r_left;
            n_await     = r_await;
            n_drain_len = r_drain_len;
            n_rd_idx    = r_rd_idx;
            n_draining  = r_draining;
        end
        if (i_cmd.rd_en) begin
            n_rd_idx = r_rd_idx + IW'(1);
        end
        if (i_cmd.load_out && r_pend_last) begin
            n_draining = 1'b0;
        end
    end

    assign o_status.single    = dec_single;
    assign o_status.drain     = dec_drain;
    assign o_status.draining  = r_draining;
    assign o_status.pend_last = r_pend_last;
    assign o_status.out_free  = out_free;

    // config registers and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sbsd_pkg::MODE_LINE;
            r_line_end   <= sbsd_pkg::LF_BYTE;
            r_strip_cr   <= 1'b1;
            r_custom_end <= '0;
            r_max_len    <= sbsd_pkg::MAX_LEN_RESET;
            r_fixed_len  <= '0;
            r_fill       <= '0;
            r_last_cr    <= 1'b0;
            r_left       <= '0;
            r_await      <= 1'b1;
            r_drain_len  <= '0;
            r_rd_idx     <= '0;
            r_draining   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbsd_pkg::REG_FRAME_MODE: r_mode       <= i_cfg_data[sbsd_pkg::MODE_W-1:0];
                    sbsd_pkg::REG_LINE_END:   r_line_end   <= i_cfg_data;
                    sbsd_pkg::REG_STRIP_CR:   r_strip_cr   <= i_cfg_data[0];
                    sbsd_pkg::REG_CUSTOM_END: r_custom_end <= i_cfg_data;
                    sbsd_pkg::REG_MAX_LEN:    r_max_len <= i_cfg_data[sbsd_pkg::MAXLEN_W-1:0];
                    sbsd_pkg::REG_FIXED_LEN:  r_fixed_len  <= i_cfg_data;
                    default: begin
                        r_mode <= r_mode;
                    end
                endcase
            end
            r_fill      <= n_fill;
            r_last_cr   <= n_last_cr;
            r_left      <= n_left;
            r_await     <= n_await;
            r_drain_len <= n_drain_len;
            r_rd_idx    <= n_rd_idx;
            r_draining  <= n_draining;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_frame_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line store, pending result, output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && dec_append) begin
            line_mem[r_fill[IW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_pend_byte <= line_mem[r_rd_idx];
            r_pend_last <= ((FW'(r_rd_idx) + FW'(1)) == r_drain_len);
            r_pend_kind <= sbsd_pkg::KIND_DATA;
        end else if (i_cmd.accept && dec_single) begin
            r_pend_byte <= dec_byte;
            r_pend_last <= dec_last;
            r_pend_kind <= dec_kind;
        end
        if (i_cmd.load_out) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= r_pend_last;
            r_out_kind <= r_pend_kind;
        end
    end

    assign o_frame_valid = r_out_valid;
    assign o_frame_byte  = r_out_byte;
    assign o_frame_last  = r_out_last;
    assign o_result_kind = r_out_kind;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_DEPTH))
        else $error("line store fill beyond depth");

    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (r_draining && (FW'(r_rd_idx) < r_drain_len)))
        else $error("line store read past released length");

    a_drain_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && dec_drain) |=> (r_drain_len != '0 && r_rd_idx == '0))
        else $error("release started with bad length");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_frame_stall) |-> !i_cmd.load_out)
        else $error("output overwritten while stalled");

endmodule

// ===== tb/serial_byte_stream_deframer_top_test.sv =====
// Self-checking testbench for the serial byte stream deframer: directed cases and random traffic, four modes.
`timescale 1ns / 100ps

module serial_byte_stream_deframer_top_test;

    localparam int DEPTH       = 64;
    localparam int SEGMENTS    = 9;     // random segments, one register setting each
    localparam int SEG_ITEMS   = 47;    // rough request count per random segment
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_LIMIT = 100000;

    // writes to these indexes must be ignored by the block
    localparam logic [sbsd_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [sbsd_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [sbsd_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic [sbsd_pkg::KIND_W-1:0] kind;
    } t_frame_res;

    // DUT ports, inputs all known from time zero
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [sbsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [sbsd_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                            i_rx_valid    = 1'b0;
    logic                            o_rx_stall;
    logic [sbsd_pkg::BYTE_W-1:0]     i_rx_byte     = '0;
    logic                            o_frame_valid;
    logic                            i_frame_stall = 1'b0;
    logic [sbsd_pkg::BYTE_W-1:0]     o_frame_byte;
    logic                            o_frame_last;
    logic [sbsd_pkg::KIND_W-1:0]     o_result_kind;

    serial_byte_stream_deframer_top #(
        .LINE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_rx_valid    (i_rx_valid),
        .o_rx_stall    (o_rx_stall),
        .i_rx_byte     (i_rx_byte),
        .o_frame_valid (o_frame_valid),
        .i_frame_stall (i_frame_stall),
        .o_frame_byte  (o_frame_byte),
        .o_frame_last  (o_frame_last),
        .o_result_kind (o_result_kind)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer prediction: own copy of registers and framing state,
    // starting at the reset values.
    // ------------------------------------------------------------------
    logic [sbsd_pkg::MODE_W-1:0]   mdl_mode       = sbsd_pkg::MODE_LINE;
    logic [sbsd_pkg::BYTE_W-1:0]   mdl_line_end   = sbsd_pkg::LF_BYTE;
    logic                          mdl_strip      = 1'b1;
    logic [sbsd_pkg::BYTE_W-1:0]   mdl_custom_end = '0;
    logic [sbsd_pkg::MAXLEN_W-1:0] mdl_max_len    = sbsd_pkg::MAX_LEN_RESET;
    logic [sbsd_pkg::BYTE_W-1:0]   mdl_fixed_len  = '0;

    logic [sbsd_pkg::BYTE_W-1:0]   held_line [DEPTH];
    int unsigned                   held_count      = 0;
    int unsigned                   frame_remaining = 0;
    bit                            want_length     = 1'b1;

    t_frame_res                    due_frames [$];   // predicted results, oldest first

    function automatic void expect_frame(logic [sbsd_pkg::BYTE_W-1:0] b, logic last,
                                         logic [sbsd_pkg::KIND_W-1:0] k);
        t_frame_res r;
        r.data = b;
        r.last = last;
        r.kind = k;
        due_frames.push_back(r);
    endfunction

    // Buffered modes: line (optionally CR stripped) and custom delimiter.
    function automatic void split_on(logic [sbsd_pkg::BYTE_W-1:0] b,
                                     logic [sbsd_pkg::BYTE_W-1:0] delim, bit strip);
        int unsigned lim;
        int unsigned n;
        int unsigned i;
        lim = (mdl_max_len > DEPTH) ? DEPTH : mdl_max_len;
        if (b == delim) begin
            n = held_count;
            if (n == 0)
                return;                   // delimiter on an empty buffer: nothing
            held_count = 0;
            if (strip && held_line[n-1] == sbsd_pkg::CR_BYTE)
                n--;
            if (n == 0) begin
                expect_frame('0, 1'b1, sbsd_pkg::KIND_EMPTY);
                return;
            end
            for (i = 0; i < n; i++)
                expect_frame(held_line[i], i + 1 == n, sbsd_pkg::KIND_DATA);
        end else if (held_count >= lim) begin
            // CR takes this path too; buffer dropped, byte discarded
            held_count = 0;
            expect_frame('0, 1'b1, sbsd_pkg::KIND_OVERFLOW);
        end else begin
            held_line[held_count] = b;
            held_count++;
        end
    endfunction

    function automatic void deframe_byte(logic [sbsd_pkg::BYTE_W-1:0] b);
        case (mdl_mode)
            sbsd_pkg::MODE_LINE: split_on(b, mdl_line_end, mdl_strip);
            sbsd_pkg::MODE_FIXED: begin
                if (mdl_fixed_len != 0) begin
                    if (frame_remaining == 0)
                        frame_remaining = mdl_fixed_len;
                    frame_remaining--;
                    expect_frame(b, frame_remaining == 0, sbsd_pkg::KIND_DATA);
                end
            end
            sbsd_pkg::MODE_LENPRE: begin
                if (want_length || frame_remaining == 0) begin
                    // zero length is skipped, still waiting for a length
                    if (b == 0) begin
                        want_length = 1'b1;
                    end else begin
                        frame_remaining = b;
                        want_length     = 1'b0;
                    end
                end else begin
                    frame_remaining--;
                    if (frame_remaining == 0)
                        want_length = 1'b1;
                    expect_frame(b, frame_remaining == 0, sbsd_pkg::KIND_DATA);
                end
            end
            default: split_on(b, mdl_custom_end, 1'b0);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: drives byte requests from the backlog queue.
    // ------------------------------------------------------------------
    logic [sbsd_pkg::BYTE_W-1:0] rx_backlog [$];
    int                          rx_unsent    = 0;   // queued but not yet accepted
    int                          items_queued = 0;
    int                          tx_idle_pct  = 29;
    int                          rx_idle_pct  = 55;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                deframe_byte(i_rx_byte);
                rx_unsent--;
            end
            // a pending request holds its byte until taken
            if (!i_rx_valid || !o_rx_stall) begin
                if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= rx_backlog.pop_front();
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks results and drives the frame-side stall.
    // A long hold-off starts once enough results have come back and the
    // sender still has bytes queued, so the block backs up into its input.
    // ------------------------------------------------------------------
    int         mismatch_count = 0;
    int         frames_seen    = 0;
    int         hold_left      = 0;
    int         hold_at        = 120;
    t_frame_res want;

    function automatic void flag(string what, logic [sbsd_pkg::BYTE_W-1:0] want_v,
                                 logic [sbsd_pkg::BYTE_W-1:0] got_v);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, what, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_frame_valid && !i_frame_stall) begin
                if (due_frames.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none, actual %0h/%0b/%0d",
                             $time, o_frame_byte, o_frame_last, o_result_kind);
                end else begin
                    want = due_frames.pop_front();
                    if (o_frame_byte !== want.data)
                        flag("frame_byte", want.data, o_frame_byte);
                    if (o_frame_last !== want.last)
                        flag("frame_last", want.last, o_frame_last);
                    if (o_result_kind !== want.kind)
                        flag("result_kind", want.kind, o_result_kind);
                end
                frames_seen++;
                if (frames_seen >= hold_at && rx_backlog.size() > 4) begin
                    hold_left = HOLD_CYCLES;
                    hold_at   = frames_seen + 240;
                end
            end
            if (hold_left != 0) begin
                i_frame_stall <= 1'b1;
                hold_left--;
            end else begin
                i_frame_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send(logic [sbsd_pkg::BYTE_W-1:0] b);
        rx_backlog.push_back(b);
        rx_unsent++;
        items_queued++;
    endtask

    // register write; prediction copy follows at once since the block is idle
    task automatic write_reg(logic [sbsd_pkg::CFG_IDX_W-1:0] idx,
                             logic [sbsd_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            sbsd_pkg::REG_FRAME_MODE: mdl_mode       = val[sbsd_pkg::MODE_W-1:0];
            sbsd_pkg::REG_LINE_END:   mdl_line_end   = val;
            sbsd_pkg::REG_STRIP_CR:   mdl_strip      = val[0];
            sbsd_pkg::REG_CUSTOM_END: mdl_custom_end = val;
            sbsd_pkg::REG_MAX_LEN:    mdl_max_len    = val[sbsd_pkg::MAXLEN_W-1:0];
            sbsd_pkg::REG_FIXED_LEN:  mdl_fixed_len  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every byte is taken and every result has come back,
    // then leave room for a byte that gives no result
    task automatic settle();
        @(posedge i_clk);
        while (rx_unsent != 0 || due_frames.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [sbsd_pkg::MODE_W-1:0]   seg_mode     [SEGMENTS];
    logic [sbsd_pkg::MAXLEN_W-1:0] seg_max_len  [SEGMENTS];
    logic [sbsd_pkg::BYTE_W-1:0]   seg_fixed_len[SEGMENTS];

    initial begin
        int                          seg;
        int                          seg_start;
        int                          len;
        int                          i;
        int                          guard;
        int unsigned                 lim;
        logic [sbsd_pkg::BYTE_W-1:0] b;
        logic [sbsd_pkg::BYTE_W-1:0] delim;

        seg_mode      = '{sbsd_pkg::MODE_LINE, sbsd_pkg::MODE_FIXED, sbsd_pkg::MODE_LENPRE,
                          sbsd_pkg::MODE_CUSTOM, sbsd_pkg::MODE_LINE, sbsd_pkg::MODE_LENPRE,
                          sbsd_pkg::MODE_FIXED, sbsd_pkg::MODE_CUSTOM, sbsd_pkg::MODE_LINE};
        seg_max_len   = '{7'd127, 7'd0, 7'd64, 7'd8, 7'd1, 7'd64, 7'd3, 7'd64, 7'd40};
        seg_fixed_len = '{8'd0, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        // reset setting (line mode, LF, CR strip): trailing CR dropped, lone CR
        // gives an empty line, LF on an empty buffer gives nothing, byte extremes
        send(8'h41); send(8'h42); send(sbsd_pkg::CR_BYTE); send(sbsd_pkg::LF_BYTE);
        send(sbsd_pkg::CR_BYTE); send(sbsd_pkg::LF_BYTE);
        send(sbsd_pkg::LF_BYTE);
        send(8'h00); send(8'hFF); send(sbsd_pkg::LF_BYTE);
        settle();

        // zero limit: every byte overflows
        write_reg(sbsd_pkg::REG_MAX_LEN, 8'd0);
        send(8'h61);
        settle();

        // limit of one: CR overflows like any other byte
        write_reg(sbsd_pkg::REG_MAX_LEN, 8'd1);
        send(8'h78); send(sbsd_pkg::CR_BYTE); send(8'h7A); send(sbsd_pkg::LF_BYTE);
        settle();

        // fixed mode with zero length discards, then frames of three
        write_reg(sbsd_pkg::REG_FRAME_MODE, {6'd0, sbsd_pkg::MODE_FIXED});
        send(8'h11); send(8'h22);
        settle();
        write_reg(sbsd_pkg::REG_FIXED_LEN, 8'd3);
        send(8'h01); send(8'h02); send(8'h03); send(8'h04);
        settle();

        // length prefix: left-over fixed count does not matter, zero length skipped
        write_reg(sbsd_pkg::REG_FRAME_MODE, {6'd0, sbsd_pkg::MODE_LENPRE});
        send(8'h00); send(8'h02); send(8'hAA); send(8'h55);
        settle();

        // custom delimiter 0x00, CR kept as data
        write_reg(sbsd_pkg::REG_FRAME_MODE, {6'd0, sbsd_pkg::MODE_CUSTOM});
        write_reg(sbsd_pkg::REG_MAX_LEN, 8'd64);
        send(8'h43); send(sbsd_pkg::CR_BYTE); send(8'h00);

        // --- random part ---
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 29;
            end
            if (seg == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            settle();
            // spare upper bits are random: the block masks them
            write_reg(sbsd_pkg::REG_FRAME_MODE, {6'($urandom), seg_mode[seg]});
            write_reg(sbsd_pkg::REG_LINE_END,
                      ($urandom_range(0, 2) == 0) ? 8'($urandom) : sbsd_pkg::LF_BYTE);
            write_reg(sbsd_pkg::REG_STRIP_CR, 8'($urandom));
            write_reg(sbsd_pkg::REG_CUSTOM_END, 8'($urandom));
            write_reg(sbsd_pkg::REG_MAX_LEN, {1'($urandom), seg_max_len[seg]});
            write_reg(sbsd_pkg::REG_FIXED_LEN, seg_fixed_len[seg]);
            write_reg(($urandom_range(0, 1) == 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                      8'($urandom));

            seg_start = items_queued;
            while (items_queued - seg_start < SEG_ITEMS) begin
                case (seg_mode[seg])
                    sbsd_pkg::MODE_FIXED: begin
                        send(8'($urandom));
                    end
                    sbsd_pkg::MODE_LENPRE: begin
                        if ($urandom_range(0, 9) == 0)
                            len = 0;
                        else if ($urandom_range(0, 9) == 0)
                            len = $urandom_range(9, 40);
                        else
                            len = $urandom_range(1, 8);
                        send(8'(len));
                        // now and then a short frame, so the next length byte is eaten
                        if (len != 0 && $urandom_range(0, 11) == 0)
                            len = $urandom_range(0, len - 1);
                        repeat (len) send(8'($urandom));
                    end
                    default: begin
                        delim = (seg_mode[seg] == sbsd_pkg::MODE_LINE) ?
                                mdl_line_end : mdl_custom_end;
                        lim   = (mdl_max_len > DEPTH) ? DEPTH : mdl_max_len;
                        if ($urandom_range(0, 7) == 0) begin
                            // noise: may leave a partial line behind
                            repeat ($urandom_range(1, 4)) send(8'($urandom));
                        end else begin
                            if ($urandom_range(0, 7) == 0)
                                len = lim + $urandom_range(0, 2);   // at or past the limit
                            else
                                len = $urandom_range(0, (lim < 10) ? lim : 10);
                            for (i = 0; i < len; i++) begin
                                do
                                    b = 8'($urandom);
                                while (b == delim);
                                if (i + 1 == len && delim != sbsd_pkg::CR_BYTE &&
                                    $urandom_range(0, 2) == 0)
                                    b = sbsd_pkg::CR_BYTE;
                                send(b);
                            end
                            send(delim);
                        end
                    end
                endcase
            end
        end

        // --- wind down ---
        guard = 0;
        while ((rx_unsent != 0 || due_frames.size() != 0) && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (due_frames.size() != 0) begin
            mismatch_count += due_frames.size();
            $display("%0t ns: missing results, expected %0d more, actual 0",
                     $time, due_frames.size());
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
